>>> rtl/ckc_pkg.sv
// Shared constants and types for the chroma key compositor.
`default_nettype none

package ckc_pkg;

    localparam int PIX_W  = 8;
    localparam int DATA_W = 6 * PIX_W;
    localparam int CFG_IDX_W = 2;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        pix_t blue;
        pix_t green;
        pix_t red;
    } rgb_t;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_CB    = 2'd0,
        REG_KEY_CR    = 2'd1,
        REG_TOLERANCE = 2'd2,
        REG_UNUSED    = 2'd3
    } cfg_reg_t;

    localparam pix_t KEY_CB_RST    = 8'd128;
    localparam pix_t KEY_CR_RST    = 8'd128;
    localparam pix_t TOLERANCE_RST = 8'd80;

    localparam pix_t PIX_WHITE = 8'd255;
    localparam rgb_t RGB_WHITE = '{blue: PIX_WHITE, green: PIX_WHITE, red: PIX_WHITE};

endpackage

`default_nettype wire

>>> rtl/chroma_key_compositor_top.sv
// Chroma key compositor: RGB to Cb/Cr, chroma distance test, pixel select.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata = fg rgb, bg rgb (48 bits)
//  m_axis    out        tdata = out rgb, mask rgb (48 bits); tuser = keyed
//  cfg       in         key_cb, key_cr, tolerance writes, no read-back
//
// One pixel per clock sustained while m_axis_tready is high; data passes through the
// four register stages: product, chroma sum, square and compare/select.
// rst_n clears all valid bits and loads the configuration registers with their reset values.
// A stall on m_axis only backs up stages that hold data; empty stages keep filling,
// so s_axis_tready drops only when all four stages are full and the output is held.
`default_nettype none

module chroma_key_compositor_top #(
    parameter int COEF_FRAC_BITS = 14
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue (from bit 0 up)
    input  wire logic [ckc_pkg::DATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // out_red, out_green, out_blue, mask_red, mask_green, mask_blue (from bit 0 up)
    output logic [ckc_pkg::DATA_W-1:0]          m_axis_tdata,
    // keyed
    output logic                                m_axis_tuser,
    input  wire logic                           cfg_we,
    input  wire logic [ckc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ckc_pkg::PIX_W-1:0]      cfg_data
);

    localparam int CW = COEF_FRAC_BITS;
    localparam int PW = COEF_FRAC_BITS + ckc_pkg::PIX_W;
    localparam int SW = COEF_FRAC_BITS + 10;

    localparam longint COEF_ONE = longint'(1) << COEF_FRAC_BITS;
    localparam longint CB_R_L   = (longint'(168736) * COEF_ONE + 500000) / 1000000;
    localparam longint CB_G_L   = (longint'(331264) * COEF_ONE + 500000) / 1000000;
    localparam longint CR_G_L   = (longint'(418688) * COEF_ONE + 500000) / 1000000;
    localparam longint CR_B_L   = (longint'(81312) * COEF_ONE + 500000) / 1000000;
    localparam longint HALF_L   = (longint'(500000) * COEF_ONE + 500000) / 1000000;
    localparam longint OFS_L    = (longint'(128) << COEF_FRAC_BITS) + COEF_ONE / 2;

    localparam logic [CW-1:0] CB_R   = CW'(CB_R_L);
    localparam logic [CW-1:0] CB_G   = CW'(CB_G_L);
    localparam logic [CW-1:0] CR_G   = CW'(CR_G_L);
    localparam logic [CW-1:0] CR_B   = CW'(CR_B_L);
    localparam logic [CW-1:0] HALF_C = CW'(HALF_L);
    localparam logic [SW-1:0] OFS    = SW'(OFS_L);

    // Rounded, offset chroma sum to a byte: negative gives 0, overflow gives 255.
    function automatic ckc_pkg::pix_t clamp_byte(input logic [SW-1:0] v);
        ckc_pkg::pix_t res;
        if (v[SW-1])
        begin
            res = '0;
        end
        else if (v[SW-2:COEF_FRAC_BITS+8] != '0)
        begin
            res = ckc_pkg::PIX_WHITE;
        end
        else
        begin
            res = v[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
        end
        return res;
    endfunction

    // Configuration registers.
    ckc_pkg::pix_t key_cb_reg, key_cr_reg, tolerance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_cb_reg    <= ckc_pkg::KEY_CB_RST;
            key_cr_reg    <= ckc_pkg::KEY_CR_RST;
            tolerance_reg <= ckc_pkg::TOLERANCE_RST;
        end
        else if (cfg_we)
        begin
            unique case (ckc_pkg::cfg_reg_t'(cfg_index))
                ckc_pkg::REG_KEY_CB:    key_cb_reg    <= cfg_data;
                ckc_pkg::REG_KEY_CR:    key_cr_reg    <= cfg_data;
                ckc_pkg::REG_TOLERANCE: tolerance_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage valid bits and per-stage advance enables.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4 = !v4_reg || m_axis_tready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_axis_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_axis_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // Stage 1: coefficient products.
    ckc_pkg::rgb_t fg_in, bg_in;
    assign fg_in = '{blue: s_axis_tdata[23:16], green: s_axis_tdata[15:8],
                     red: s_axis_tdata[7:0]};
    assign bg_in = '{blue: s_axis_tdata[47:40], green: s_axis_tdata[39:32],
                     red: s_axis_tdata[31:24]};

    logic [PW-1:0] p_cb_b_reg, p_cb_r_reg, p_cb_g_reg;
    logic [PW-1:0] p_cr_r_reg, p_cr_g_reg, p_cr_b_reg;
    ckc_pkg::rgb_t fg1_reg, bg1_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            p_cb_b_reg <= PW'(fg_in.blue) * PW'(HALF_C);
            p_cb_r_reg <= PW'(fg_in.red) * PW'(CB_R);
            p_cb_g_reg <= PW'(fg_in.green) * PW'(CB_G);
            p_cr_r_reg <= PW'(fg_in.red) * PW'(HALF_C);
            p_cr_g_reg <= PW'(fg_in.green) * PW'(CR_G);
            p_cr_b_reg <= PW'(fg_in.blue) * PW'(CR_B);
            fg1_reg    <= fg_in;
            bg1_reg    <= bg_in;
        end
    end

    // Stage 2: chroma sums with rounding and clamp.
    logic [SW-1:0] cb_sum, cr_sum;
    assign cb_sum = SW'(p_cb_b_reg) + OFS - SW'(p_cb_r_reg) - SW'(p_cb_g_reg);
    assign cr_sum = SW'(p_cr_r_reg) + OFS - SW'(p_cr_g_reg) - SW'(p_cr_b_reg);

    ckc_pkg::pix_t cb2_reg, cr2_reg;
    ckc_pkg::rgb_t fg2_reg, bg2_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            cb2_reg <= clamp_byte(cb_sum);
            cr2_reg <= clamp_byte(cr_sum);
            fg2_reg <= fg1_reg;
            bg2_reg <= bg1_reg;
        end
    end

    // Stage 3: squared distances to the key and tolerance squared.
    logic signed [8:0]  dcb, dcr;
    logic signed [17:0] sq_cb_full, sq_cr_full;
    logic [15:0]        tol_sq;

    assign dcb        = $signed({1'b0, cb2_reg}) - $signed({1'b0, key_cb_reg});
    assign dcr        = $signed({1'b0, cr2_reg}) - $signed({1'b0, key_cr_reg});
    assign sq_cb_full = dcb * dcb;
    assign sq_cr_full = dcr * dcr;
    assign tol_sq     = {8'd0, tolerance_reg} * {8'd0, tolerance_reg};

    logic [15:0]   sq_cb3_reg, sq_cr3_reg, tol_sq3_reg;
    ckc_pkg::rgb_t fg3_reg, bg3_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            sq_cb3_reg  <= sq_cb_full[15:0];
            sq_cr3_reg  <= sq_cr_full[15:0];
            tol_sq3_reg <= tol_sq;
            fg3_reg     <= fg2_reg;
            bg3_reg     <= bg2_reg;
        end
    end

    // Stage 4: compare and select into the output register.
    logic [16:0] dist_sq;
    logic        hit;
    assign dist_sq = {1'b0, sq_cb3_reg} + {1'b0, sq_cr3_reg};
    assign hit     = dist_sq < {1'b0, tol_sq3_reg};

    ckc_pkg::rgb_t out4_reg, mask4_reg;
    logic          keyed4_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            out4_reg   <= hit ? bg3_reg : fg3_reg;
            mask4_reg  <= hit ? fg3_reg : ckc_pkg::RGB_WHITE;
            keyed4_reg <= hit;
        end
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = {mask4_reg.blue, mask4_reg.green, mask4_reg.red,
                            out4_reg.blue, out4_reg.green, out4_reg.red};
    assign m_axis_tuser  = keyed4_reg;

endmodule

`default_nettype wire

>>> rtl/ckc_checker.sv
// Port-level checks for the chroma key compositor, bound to the top level.
`default_nettype none

module ckc_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        s_axis_tvalid,
    input wire logic                        s_axis_tready,
    input wire logic                        m_axis_tvalid,
    input wire logic                        m_axis_tready,
    input wire logic [ckc_pkg::DATA_W-1:0]  m_axis_tdata,
    input wire logic                        m_axis_tuser
);

    // A held result keeps its payload until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // A pixel that was not keyed carries a white mask.
    a_white_mask: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[ckc_pkg::DATA_W-1:3*ckc_pkg::PIX_W] == {3{ckc_pkg::PIX_WHITE}})
        else $error("mask not white on an unkeyed pixel");

    // The input side only backs up when the output holds an untaken result.
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with room in the pipeline");

    // Nothing comes out in the cycle right after reset is released.
    a_reset_empty: assert property (@(posedge clk)
        $past(!rst_n) |-> !m_axis_tvalid)
        else $error("result present right after reset");

endmodule

bind chroma_key_compositor_top ckc_checker u_ckc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
